>>> hdl/assert_macros.svh
// Assertion macros shared by the cache RTL files.
// Depends on nothing; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_ALWAYS(label, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_ALWAYS(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

>>> hdl/lkvc_pkg.sv
// Shared constants, types and codes of the LRU key-value cache.
// Used by lkvc_match, lkvc_store and the top level; depends on nothing.
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 5;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int PADDR_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Register index taken from the word address.
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic {
        FUNC_GET = 1'b0,
        FUNC_SET = 1'b1
    } func_t;

    typedef logic signed [DATA_W-1:0]       data_t;
    typedef logic [IDX_W-1:0]               rank_t;
    typedef logic [CNT_W-1:0]               count_t;
    typedef logic [ENTRIES-1:0]             slot_vec_t;
    typedef logic [ENTRIES-1:0][DATA_W-1:0] data_arr_t;
    typedef logic [ENTRIES-1:0][IDX_W-1:0]  rank_arr_t;

    localparam data_t MISS_VALUE = '1;

    // Outcome of one lookup against all entries.
    typedef struct packed {
        logic      hit;
        data_t     read_value;
        slot_vec_t target;
        count_t    thresh;
        logic      insert;
    } match_t;

    // Write command into the entry store.
    typedef struct packed {
        logic      we;
        slot_vec_t target;
        count_t    thresh;
        logic      insert;
        data_t     key;
        data_t     value;
    } write_t;

endpackage

`default_nettype wire

>>> hdl/lkvc_match.sv
// Parallel key compare, victim and free-slot selection for the cache.
// Depends on lkvc_pkg; purely combinational.
`default_nettype none

module lkvc_match (
    input  wire lkvc_pkg::slot_vec_t valid,
    input  wire lkvc_pkg::data_arr_t keys,
    input  wire lkvc_pkg::data_arr_t values,
    input  wire lkvc_pkg::rank_arr_t ranks,
    input  wire lkvc_pkg::count_t    count,
    input  wire lkvc_pkg::count_t    eff_cap,
    input  wire lkvc_pkg::data_t     key,
    output lkvc_pkg::match_t         result
);
    import lkvc_pkg::*;

    slot_vec_t hit_vec;
    slot_vec_t victim_vec;
    slot_vec_t free_vec;
    data_t     hit_value;
    rank_t     hit_rank;
    logic      hit;
    logic      evict;

    // Ranks of valid entries form a permutation of 0..count-1, so the
    // least recent entry is the one whose rank equals count-1. Entries are
    // never dropped, so the valid slots are exactly 0..count-1.
    always_comb begin
        hit_value = '0;
        hit_rank  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i]    = valid[i] && (keys[i] == key);
            victim_vec[i] = valid[i] && (CNT_W'(ranks[i]) == (count - CNT_W'(1)));
            free_vec[i]   = (CNT_W'(i) == count);
            hit_value     = hit_value | (values[i] & {DATA_W{hit_vec[i]}});
            hit_rank      = hit_rank | (ranks[i] & {IDX_W{hit_vec[i]}});
        end
    end

    assign hit   = |hit_vec;
    assign evict = (count >= eff_cap);

    always_comb begin
        result.hit        = hit;
        result.read_value = hit ? hit_value : MISS_VALUE;
        result.insert     = !hit && !evict;
        if (hit) begin
            result.target = hit_vec;
            result.thresh = CNT_W'(hit_rank);
        end else if (evict) begin
            result.target = victim_vec;
            result.thresh = count - CNT_W'(1);
        end else begin
            result.target = free_vec;
            result.thresh = count;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lkvc_store.sv
// Entry storage of the cache: valid bits, keys, values, recency ranks, count.
// Depends on lkvc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lkvc_store (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire lkvc_pkg::write_t    wr,
    output lkvc_pkg::slot_vec_t      valid,
    output lkvc_pkg::data_arr_t      keys,
    output lkvc_pkg::data_arr_t      values,
    output lkvc_pkg::rank_arr_t      ranks,
    output lkvc_pkg::count_t         count
);
    import lkvc_pkg::*;

    slot_vec_t valid_reg, valid_next;
    data_arr_t key_reg;
    data_arr_t value_reg;
    rank_arr_t rank_reg, rank_next;
    count_t    count_reg, count_next;

    // The target becomes most recent; every other valid entry ranked below
    // the threshold ages by one.
    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        if (wr.we) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (wr.target[i]) begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = '0;
                end else if (valid_reg[i] && (CNT_W'(rank_reg[i]) < wr.thresh)) begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
            if (wr.insert) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rank_reg  <= '0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (wr.we && wr.target[i]) begin
                key_reg[i]   <= wr.key;
                value_reg[i] <= wr.value;
            end
        end
    end

    assign valid  = valid_reg;
    assign keys   = key_reg;
    assign values = value_reg;
    assign ranks  = rank_reg;
    assign count  = count_reg;

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(ENTRIES), "count above depth")
    `ASSERT_ALWAYS(a_count_valid, aclk, aresetn, $countones(valid_reg) == int'(count_reg), "count differs from valid bits")
    `ASSERT_NEXT(a_insert_grows, aclk, aresetn, wr.we && wr.insert, count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow count")

endmodule

`default_nettype wire

>>> hdl/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lkvc_pkg, lkvc_match, lkvc_store and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Usage
// The input stream carries one access per beat: s_tuser selects get (0) or
// set (1), s_tdata holds the key in its low word and the value to store in
// its high word. A get answers with one beat on the output stream: m_tuser
// is the found flag, m_tdata the stored value, or all ones on a miss. A set
// answers nothing; it updates a present key and makes it most recent, or
// inserts a new key and, once the count has reached the capacity, replaces
// the least recent entry.
// Timing: a beat is registered at acceptance and resolved from the input
// register by sixteen parallel key compares, with a rank update for a set;
// a get's result is then registered. One beat is taken every cycle while
// s_tready is high; the state written by one access is seen by the very next one.
// Stalls: while the result register is full and m_tready is low, a get
// waiting in the input register holds there and s_tready drops; sets keep
// flowing until a get reaches the input register.
// Reset (aresetn low, synchronous) empties the cache, clears all ranks and
// sets the capacity register to sixteen. The capacity register sits at APB
// address 0; write it only while no access is in flight.

module lru_key_value_cache_core (
    input  wire                         aclk,
    input  wire                         aresetn,
    // Input stream
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [63:0]                 s_tdata,   // [31:0] lookup_key, [63:32] store_value
    input  wire  [0:0]                  s_tuser,   // [0] func
    // Result stream
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [31:0]                 m_tdata,   // [31:0] read_value
    output logic [0:0]                  m_tuser,   // [0] found
    // Configuration port
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [lkvc_pkg::PADDR_W-1:0] paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import lkvc_pkg::*;

    // Input register
    logic      in_valid_reg, in_valid_next;
    func_t     in_func_reg;
    data_t     in_key_reg;
    data_t     in_value_reg;

    // Result register
    logic      m_tvalid_reg, m_tvalid_next;
    data_t     m_tdata_reg;
    logic      m_tuser_reg;

    // Capacity register and its clamped form
    logic [CAP_W-1:0] capacity_reg, capacity_next;
    count_t           eff_cap;

    logic      out_free;
    logic      advance;
    logic      cfg_write;
    logic      get_blocked;

    slot_vec_t valid;
    data_arr_t keys;
    data_arr_t values;
    rank_arr_t ranks;
    count_t    count;
    match_t    mres;
    write_t    wr;

    // A get needs room in the result register; a set never waits.
    assign out_free = !m_tvalid_reg || m_tready;
    assign advance  = in_valid_reg && ((in_func_reg == FUNC_SET) || out_free);
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;
    assign m_tvalid_next = out_free ? (advance && (in_func_reg == FUNC_GET)) : m_tvalid_reg;

    // A get is held back only by a full result register that is not drained.
    assign get_blocked = in_valid_reg && (in_func_reg == FUNC_GET) && m_tvalid_reg && !m_tready;

    // Configuration: the word index is paddr[2]; only index zero exists.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign capacity_next = cfg_write ? pwdata[CAP_W-1:0] : capacity_reg;
    assign prdata    = (paddr[2] == REG_CAPACITY) ? 32'(capacity_reg) : '0;

    // A capacity of zero acts as one, and anything above the depth as the depth.
    always_comb begin
        if (capacity_reg == '0) begin
            eff_cap = CNT_W'(1);
        end else if (32'(capacity_reg) > 32'(ENTRIES)) begin
            eff_cap = CNT_W'(ENTRIES);
        end else begin
            eff_cap = CNT_W'(capacity_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            capacity_reg <= CAP_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            capacity_reg <= capacity_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg  <= func_t'(s_tuser[0]);
            in_key_reg   <= s_tdata[31:0];
            in_value_reg <= s_tdata[63:32];
        end
        if (advance && (in_func_reg == FUNC_GET)) begin
            m_tdata_reg <= mres.read_value;
            m_tuser_reg <= mres.hit;
        end
    end

    lkvc_match u_match (
        .valid   (valid),
        .keys    (keys),
        .values  (values),
        .ranks   (ranks),
        .count   (count),
        .eff_cap (eff_cap),
        .key     (in_key_reg),
        .result  (mres)
    );

    always_comb begin
        wr.we     = advance && (in_func_reg == FUNC_SET);
        wr.target = mres.target;
        wr.thresh = mres.thresh;
        wr.insert = mres.insert;
        wr.key    = in_key_reg;
        wr.value  = in_value_reg;
    end

    lkvc_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .valid   (valid),
        .keys    (keys),
        .values  (values),
        .ranks   (ranks),
        .count   (count)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_IMPLY(a_stall_cause, aclk, aresetn, !s_tready, get_blocked, "stall without cause")
    `ASSERT_IMPLY(a_single_target, aclk, aresetn, wr.we, $onehot(mres.target), "set target")

endmodule

`default_nettype wire
